### hw/rtl/kvct_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the key/value cam table
// used by kvct_cell and key_value_cam_table_top, no dependencies
package kvct_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int KEY_W         = 64;
    localparam int VAL_W         = 64;

    typedef logic [IDX_W-1:0] t_idx;

    // opcodes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_CONFLICT  = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // query token handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic [1:0]       opcode;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic             hit;
        t_idx             hit_idx;
        logic [VAL_W-1:0] hit_value;
        logic             free;
        t_idx             free_idx;
    } t_token;

    // table update broadcast back to the cells
    typedef struct packed {
        logic             set;
        logic             clear;
        t_idx             idx;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_commit;

endpackage

### hw/rtl/kvct_cell.sv
`timescale 1ns / 1ps
// one table slot: holds valid/key/value and passes the query token on
// depends on kvct_pkg
module kvct_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kvct_pkg::t_idx    i_index,
    input  kvct_pkg::t_token  i_tok,
    input  kvct_pkg::t_commit i_commit,
    output kvct_pkg::t_token  o_tok
);

    logic                      r_valid;
    logic [kvct_pkg::KEY_W-1:0] r_key;
    logic [kvct_pkg::VAL_W-1:0] r_value;
    logic                      r_tok_valid;
    kvct_pkg::t_token          r_tok;
    kvct_pkg::t_token          n_tok;
    logic                      w_match;
    logic                      w_sel;

    assign w_match = r_valid && (r_key == i_tok.key);
    assign w_sel   = (i_commit.idx == i_index);

    always_comb begin
        n_tok = i_tok;
        // first matching slot wins, table keeps keys unique anyway
        if (w_match && !i_tok.hit) begin
            n_tok.hit       = 1'b1;
            n_tok.hit_idx   = i_index;
            n_tok.hit_value = r_value;
        end
        // lowest free slot
        if (!r_valid && !i_tok.free) begin
            n_tok.free     = 1'b1;
            n_tok.free_idx = i_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_tok_valid <= 1'b0;
        end else begin
            r_tok_valid <= n_tok.valid;
            if (w_sel && i_commit.set) begin
                r_valid <= 1'b1;
            end else if (w_sel && i_commit.clear) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
        if (w_sel && i_commit.set) begin
            r_key   <= i_commit.key;
            r_value <= i_commit.value;
        end
    end

    always_comb begin
        o_tok       = r_tok;
        o_tok.valid = r_tok_valid;
    end

endmodule

### hw/rtl/key_value_cam_table_top.sv
`timescale 1ns / 1ps
// an item passes one slot cell per cycle (the first at acceptance); at the end of
// the row it is resolved, and the table update and the pending result register load
// together; the result then moves into the output register once that is empty or read.
// one item at a time: a new item is accepted only after the last result has moved on.
// synchronous active-low reset clears all valid bits; the table starts empty.
// depends on kvct_pkg and kvct_cell
module key_value_cam_table_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,  // key [63:0], value_in [127:64]
    input  logic [1:0]    s_axis_tuser,  // opcode [1:0]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [63:0]   m_axis_tdata,  // value_out [63:0]
    output logic [1:0]    m_axis_tuser   // status [1:0]
);

    localparam int N = kvct_pkg::TABLE_ENTRIES;

    kvct_pkg::t_token  w_tok [0:N];
    kvct_pkg::t_token  w_head;
    kvct_pkg::t_commit w_commit;
    kvct_pkg::t_token  w_end;
    logic [N-1:0]      w_tok_valid;

    logic                       r_busy;
    logic                       r_pend_valid;
    logic [1:0]                 r_pend_status;
    logic [kvct_pkg::VAL_W-1:0] r_pend_value;
    logic                       r_out_valid;
    logic [1:0]                 r_out_status;
    logic [kvct_pkg::VAL_W-1:0] r_out_value;

    logic [1:0]                 w_status;
    logic [kvct_pkg::VAL_W-1:0] w_value;
    logic                       w_accept;
    logic                       w_out_load;

    assign s_axis_tready = !r_busy;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        w_head           = '0;
        w_head.valid     = w_accept;
        w_head.opcode    = s_axis_tuser;
        w_head.key       = s_axis_tdata[63:0];
        w_head.value     = s_axis_tdata[127:64];
    end

    assign w_tok[0] = w_head;

    for (genvar i = 0; i < N; i++) begin : g_cell
        kvct_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_index  (kvct_pkg::t_idx'(i)),
            .i_tok    (w_tok[i]),
            .i_commit (w_commit),
            .o_tok    (w_tok[i+1])
        );
        assign w_tok_valid[i] = w_tok[i+1].valid;
    end

    assign w_end = w_tok[N];

    // resolve the item at the end of the row
    always_comb begin
        w_status       = kvct_pkg::ST_NOT_FOUND;
        w_value        = '0;
        w_commit       = '0;
        w_commit.key   = w_end.key;
        w_commit.value = w_end.value;
        case (w_end.opcode)
            kvct_pkg::OP_INSERT: begin
                if (w_end.hit) begin
                    w_status = (w_end.hit_value == w_end.value) ? kvct_pkg::ST_OK
                                                                : kvct_pkg::ST_CONFLICT;
                end else if (w_end.free) begin
                    w_status     = kvct_pkg::ST_OK;
                    w_commit.set = w_end.valid;
                    w_commit.idx = w_end.free_idx;
                end else begin
                    w_status = kvct_pkg::ST_FULL;
                end
            end
            kvct_pkg::OP_REMOVE: begin
                if (w_end.hit) begin
                    w_status       = kvct_pkg::ST_OK;
                    w_commit.clear = w_end.valid;
                    w_commit.idx   = w_end.hit_idx;
                end
            end
            kvct_pkg::OP_LOOKUP: begin
                if (w_end.hit) begin
                    w_status = kvct_pkg::ST_OK;
                    w_value  = w_end.hit_value;
                end
            end
            default: begin
                w_status = kvct_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    assign w_out_load = r_pend_valid && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_out_load) begin
                r_busy <= 1'b0;
            end
            if (w_end.valid) begin
                r_pend_valid <= 1'b1;
            end else if (w_out_load) begin
                r_pend_valid <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_end.valid) begin
            r_pend_status <= w_status;
            r_pend_value  <= w_value;
        end
        if (w_out_load) begin
            r_out_status <= r_pend_status;
            r_out_value  <= r_pend_value;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = r_out_status;

`ifndef NO_ASSERTIONS
    a_one_item_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_valid))
        else $error("more than one item in the cell row");

    a_set_clear_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_commit.set && w_commit.clear))
        else $error("table set and clear at once");

    a_pend_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end.valid |-> !r_pend_valid)
        else $error("result arrived while previous one pending");

    a_busy_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_end.valid || r_pend_valid || (|w_tok_valid)) |-> r_busy)
        else $error("item in flight while not busy");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != kvct_pkg::ST_OK)) |-> (r_out_value == '0))
        else $error("nonzero value on failed item");
`endif

endmodule
